// File: rtl/core/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_RAW(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cv3_pkg.sv
`timescale 1ns / 1ps

package cv3_pkg;

  localparam int PIX_W     = 8;
  localparam int PIX_MAX   = 255;
  localparam int COEF_W    = 16;
  localparam int CFG_W     = 48;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 16;
  localparam int IN_ROW_W  = 17;
  localparam int KERN      = 3;
  localparam int TAPS      = KERN * KERN;
  localparam int PROD_W    = 25;
  localparam int ROW_W     = 27;
  localparam int SUM_W     = 29;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic OP_FLUSH = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST    = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 16'd1024;
  localparam logic [CFG_W-1:0]    COEF_TOP_RST = 48'd549772591232;
  localparam logic [CFG_W-1:0]    COEF_MID_RST = 48'd1099545182464;
  localparam logic [CFG_W-1:0]    COEF_BOT_RST = 48'd549772591232;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 3'd0,
    CFG_HEIGHT   = 3'd1,
    CFG_COEF_TOP = 3'd2,
    CFG_COEF_MID = 3'd3,
    CFG_COEF_BOT = 3'd4
  } cfg_idx_t;

  // Window taps that fall outside the image
  typedef struct packed {
    logic top_skip;
    logic bot_skip;
    logic left_skip;
    logic right_skip;
  } edge_t;

  // One output job: masked 3x3 window, row-major, top-left at index 0
  typedef struct packed {
    logic [TAPS-1:0][PIX_W-1:0] pix;
    logic                       last;
  } job_t;

  typedef logic [KERN-1:0][CFG_W-1:0] coef_rows_t;

endpackage

// File: rtl/core/cv3_front.sv
`timescale 1ns / 1ps

module cv3_front import cv3_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic                in_op,
  input  logic [PIX_W-1:0]    in_pixel_in,
  input  logic [WIDTH_W-1:0]  cfg_width,
  input  logic [HEIGHT_W-1:0] cfg_height,
  input  logic [Q_CNT_W-1:0]  q_count,
  output logic                job_push,
  output job_t                job
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WLIM_W = $clog2(MAX_WIDTH + 1);
  localparam logic [COL_W-1:0] LAST_ADDR = COL_W'(MAX_WIDTH - 1);

  // Line store: {older row, newer row} per column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_q_r;
  logic [2*PIX_W-1:0] byp_data_r;
  logic               byp_r;

  logic               clearing_r;
  logic [COL_W-1:0]   clr_addr_r;

  logic [COL_W-1:0]    in_col_r,  in_col_nxt;
  logic [IN_ROW_W-1:0] in_row_r,  in_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [HEIGHT_W-1:0] out_row_r, out_row_nxt;

  logic [WLIM_W-1:0]   eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic draining, take, emit, last, col_wrap_in, col_wrap_out, row_last_out;
  edge_t edge_cur;
  logic [PIX_W-1:0] val;

  logic               s1_v_r;
  logic [COL_W-1:0]   s1_idx_r;
  logic [PIX_W-1:0]   s1_val_r;
  logic               s1_emit_r;
  logic               s1_last_r;
  edge_t              s1_edge_r;

  logic [PIX_W-1:0] top, mid;
  logic [TAPS-1:0][PIX_W-1:0] win_r, win_new, job_pix;

  logic               wr_en;
  logic [COL_W-1:0]   wr_addr;
  logic [2*PIX_W-1:0] wr_data;

  // Clamp the configured frame size
  always_comb begin
    if (cfg_width == '0) begin
      eff_w = WLIM_W'(1);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      eff_w = WLIM_W'(MAX_WIDTH);
    end else begin
      eff_w = WLIM_W'(cfg_width);
    end
    eff_h = (cfg_height == '0) ? HEIGHT_W'(1) : cfg_height;
  end

  // Hold off input during the clear pass or when the queue may overflow
  assign full = clearing_r || ((32'(q_count) + 32'(job_push)) >= Q_DEPTH);

  // Classify the incoming word
  assign draining     = 32'(in_row_r) >= 32'(eff_h);
  assign take         = push && !full && !(in_op == OP_FLUSH && !draining);
  assign val          = draining ? '0 : in_pixel_in;
  assign emit         = (in_row_r >= IN_ROW_W'(2)) ||
                        ((in_row_r == IN_ROW_W'(1)) && (in_col_r != '0));
  assign col_wrap_in  = (32'(in_col_r) + 32'd1) >= 32'(eff_w);
  assign col_wrap_out = (32'(out_col_r) + 32'd1) >= 32'(eff_w);
  assign row_last_out = (32'(out_row_r) + 32'd1) >= 32'(eff_h);
  assign last         = col_wrap_out && row_last_out;

  assign edge_cur.top_skip   = (out_row_r == '0);
  assign edge_cur.bot_skip   = row_last_out;
  assign edge_cur.left_skip  = (out_col_r == '0);
  assign edge_cur.right_skip = col_wrap_out;

  // Advance the raster counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (take) begin
      if (col_wrap_in) begin
        in_col_nxt = '0;
        if (in_row_r != '1) begin
          in_row_nxt = in_row_r + IN_ROW_W'(1);
        end
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (emit) begin
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (col_wrap_out) begin
          out_col_nxt = '0;
          if (out_row_r != '1) begin
            out_row_nxt = out_row_r + HEIGHT_W'(1);
          end
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Sweep the line store to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + COL_W'(1);
      end
    end
  end

  // Line store port: read at the incoming column, write back in stage one
  assign wr_en   = clearing_r || s1_v_r;
  assign wr_addr = clearing_r ? clr_addr_r : s1_idx_r;
  assign wr_data = clearing_r ? '0 : {mid, s1_val_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    mem_q_r    <= line_mem[in_col_r];
    byp_r      <= wr_en && (wr_addr == in_col_r);
    byp_data_r <= wr_data;
  end

  // Stage one registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_idx_r  <= in_col_r;
      s1_val_r  <= val;
      s1_emit_r <= emit;
      s1_last_r <= emit && last;
      s1_edge_r <= edge_cur;
    end
  end

  // Forward the write that lands on the column just read
  assign top = byp_r ? byp_data_r[2*PIX_W-1:PIX_W] : mem_q_r[2*PIX_W-1:PIX_W];
  assign mid = byp_r ? byp_data_r[PIX_W-1:0]       : mem_q_r[PIX_W-1:0];

  // Shift the window and drop taps outside the image
  always_comb begin
    for (int r = 0; r < KERN; r++) begin
      win_new[r*KERN]     = win_r[r*KERN + 1];
      win_new[r*KERN + 1] = win_r[r*KERN + 2];
    end
    win_new[KERN - 1]   = top;
    win_new[2*KERN - 1] = mid;
    win_new[TAPS - 1]   = s1_val_r;
    job_pix = win_new;
    for (int c = 0; c < KERN; c++) begin
      if (s1_edge_r.top_skip) begin
        job_pix[c] = '0;
      end
      if (s1_edge_r.bot_skip) begin
        job_pix[(KERN-1)*KERN + c] = '0;
      end
    end
    for (int r = 0; r < KERN; r++) begin
      if (s1_edge_r.left_skip) begin
        job_pix[r*KERN] = '0;
      end
      if (s1_edge_r.right_skip) begin
        job_pix[r*KERN + KERN - 1] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_v_r) begin
      win_r <= win_new;
    end
  end

  assign job_push = s1_v_r && s1_emit_r;
  assign job.pix  = job_pix;
  assign job.last = s1_last_r;

endmodule

// File: rtl/core/cv3_queue.sv
`timescale 1ns / 1ps

module cv3_queue import cv3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  job_t               din,
  input  logic               pop,
  output job_t               dout,
  output logic               valid,
  output logic [Q_CNT_W-1:0] count
);

  job_t                q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  count_r;

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= din;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

  assign dout  = q_mem[rd_ptr_r];
  assign valid = (count_r != '0);
  assign count = count_r;

endmodule

// File: rtl/core/cv3_back.sv
`timescale 1ns / 1ps

module cv3_back import cv3_pkg::*; #(
  parameter int COEF_FRAC_BITS = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  job_t             job,
  output logic             job_pop,
  input  coef_rows_t       coef,
  input  logic             pop,
  output logic             empty,
  output logic [PIX_W-1:0] pixel_out,
  output logic             frame_last
);

  localparam logic signed [SUM_W-1:0] MAX_SUM  = SUM_W'(PIX_MAX << COEF_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1 << (COEF_FRAC_BITS - 1));

  logic adv;

  logic                     p1_v_r, p2_v_r, p3_v_r, o_v_r;
  logic                     p1_last_r, p2_last_r, p3_last_r, o_last_r;
  logic signed [PROD_W-1:0] prod_nxt [TAPS];
  logic signed [PROD_W-1:0] prod_r   [TAPS];
  logic signed [ROW_W-1:0]  row_nxt  [KERN];
  logic signed [ROW_W-1:0]  row_r    [KERN];
  logic signed [SUM_W-1:0]  sum_nxt, sum_r;
  logic signed [SUM_W-1:0]  clamped, rounded;
  logic [PIX_W-1:0]         pix_nxt, pix_r;

  // Whole pipe moves unless the output word is held
  assign adv     = !o_v_r || pop;
  assign job_pop = adv && job_valid;

  // Tap products
  always_comb begin
    for (int r = 0; r < KERN; r++) begin
      for (int c = 0; c < KERN; c++) begin
        prod_nxt[r*KERN + c] = PROD_W'($signed({1'b0, job.pix[r*KERN + c]})) *
                               PROD_W'($signed(coef[r][c*COEF_W +: COEF_W]));
      end
    end
  end

  // Row sums
  always_comb begin
    for (int r = 0; r < KERN; r++) begin
      row_nxt[r] = ROW_W'(prod_r[r*KERN]) + ROW_W'(prod_r[r*KERN + 1]) +
                   ROW_W'(prod_r[r*KERN + 2]);
    end
  end

  assign sum_nxt = SUM_W'(row_r[0]) + SUM_W'(row_r[1]) + SUM_W'(row_r[2]);

  // Clamp, then round half up
  always_comb begin
    if (sum_r[SUM_W-1]) begin
      clamped = '0;
    end else if (sum_r > MAX_SUM) begin
      clamped = MAX_SUM;
    end else begin
      clamped = sum_r;
    end
    rounded = clamped + HALF_LSB;
    pix_nxt = rounded[COEF_FRAC_BITS +: PIX_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (adv) begin
      p1_v_r <= job_valid;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      o_v_r  <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r    <= prod_nxt;
      p1_last_r <= job.last;
      row_r     <= row_nxt;
      p2_last_r <= p1_last_r;
      sum_r     <= sum_nxt;
      p3_last_r <= p2_last_r;
      pix_r     <= pix_nxt;
      o_last_r  <= p3_last_r;
    end
  end

  assign empty      = !o_v_r;
  assign pixel_out  = pix_r;
  assign frame_last = o_last_r;

endmodule

// File: rtl/core/conv3x3_zero_pad_clamp_top.sv
`timescale 1ns / 1ps
// Streaming 3x3 convolution, one pixel word per clock sustained while full is low.
// A result passes through stage one, the job queue and the product, row-sum, sum and output registers.
// Throughput: 1 word per cycle while full is low; the line store has one write and one read per cycle.
// Reset: synchronous, active low; afterwards full stays high
// while the line store is swept to zero. Config writes are taken at any time.

module conv3x3_zero_pad_clamp_top import cv3_pkg::*; #(
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_op,
  input  logic [PIX_W-1:0]     in_pixel_in,
  output logic                 empty,
  input  logic                 pop,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_frame_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  coef_rows_t          coef_r;

  logic               job_push;
  job_t               job_in;
  job_t               job_out;
  logic               job_valid;
  logic               job_pop;
  logic [Q_CNT_W-1:0] q_count;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      coef_r[0] <= COEF_TOP_RST;
      coef_r[1] <= COEF_MID_RST;
      coef_r[2] <= COEF_BOT_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:    width_r   <= cfg_data[WIDTH_W-1:0];
        CFG_HEIGHT:   height_r  <= cfg_data[HEIGHT_W-1:0];
        CFG_COEF_TOP: coef_r[0] <= cfg_data;
        CFG_COEF_MID: coef_r[1] <= cfg_data;
        CFG_COEF_BOT: coef_r[2] <= cfg_data;
        default:      ;
      endcase
    end
  end

  cv3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_op       (in_op),
    .in_pixel_in (in_pixel_in),
    .cfg_width   (width_r),
    .cfg_height  (height_r),
    .q_count     (q_count),
    .job_push    (job_push),
    .job         (job_in)
  );

  cv3_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_out),
    .valid (job_valid),
    .count (q_count)
  );

  cv3_back #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job_out),
    .job_pop    (job_pop),
    .coef       (coef_r),
    .pop        (pop),
    .empty      (empty),
    .pixel_out  (out_pixel_out),
    .frame_last (out_frame_last)
  );

endmodule

// File: rtl/core/cv3_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cv3_checker import cv3_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [PIX_W-1:0] out_pixel_out,
  input logic             out_frame_last,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // Reset leaves no result and blocks input
  `ASSERT_NEXT_RAW(a_reset_state, clk, !rst_n, empty && full, "reset did not empty and block")

  // Line store sweep still running on the first cycle out of reset
  `ASSERT_NOW(a_clear_pass, clk, rst_n, $rose(rst_n), full, "input open before clear pass")

  // Config writes are never stalled
  `ASSERT_NOW(a_cfg_taken, clk, rst_n, cfg_valid, cfg_ready, "config write stalled")

  // A waiting word stays put until popped
  `ASSERT_NEXT(a_out_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_pixel_out) && $stable(out_frame_last), "held word changed")

endmodule

bind conv3x3_zero_pad_clamp_top cv3_checker u_checker (.*);
